// ===== hdl/ufs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_pkg
// Types, codes and constants shared by the URL field splitter.
// ----------------------------------------------------------------------------
package ufs_pkg;

    localparam int BYTE_W  = 8;
    localparam int PORT_W  = 16;
    localparam int TAG_W   = 3;
    localparam int ODATA_W = 32;

    localparam logic [PORT_W-1:0] DEFAULT_PORT = 16'd80;
    localparam logic [PORT_W-1:0] PORT_MAX     = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CH_COLON    = 8'd58;
    localparam logic [BYTE_W-1:0] CH_SLASH    = 8'd47;
    localparam logic [BYTE_W-1:0] CH_QUESTION = 8'd63;
    localparam logic [BYTE_W-1:0] CH_DOT      = 8'd46;
    localparam logic [BYTE_W-1:0] CH_DASH     = 8'd45;
    localparam logic [BYTE_W-1:0] CH_ZERO     = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE     = 8'd57;
    localparam logic [BYTE_W-1:0] CH_UP_A     = 8'd65;
    localparam logic [BYTE_W-1:0] CH_UP_Z     = 8'd90;
    localparam logic [BYTE_W-1:0] CH_LO_A     = 8'd97;
    localparam logic [BYTE_W-1:0] CH_LO_Z     = 8'd122;
    localparam logic [BYTE_W-1:0] LOWER_BASE  = 8'd96;
    localparam logic [BYTE_W-1:0] ASCII_TOP   = 8'd128;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'd32;

    typedef enum logic [2:0] {
        PH_SCHEME = 3'd0,
        PH_SLASH  = 3'd1,
        PH_SELECT = 3'd2,
        PH_HOST   = 3'd3,
        PH_PATH   = 3'd4,
        PH_PORT   = 3'd5,
        PH_PARAM  = 3'd6
    } t_phase;

    typedef enum logic [TAG_W-1:0] {
        TAG_SCHEME = 3'd0,
        TAG_DELIM  = 3'd1,
        TAG_HOST   = 3'd2,
        TAG_PORT   = 3'd3,
        TAG_PATH   = 3'd4,
        TAG_PARAM  = 3'd5,
        TAG_ERR    = 3'd6
    } t_tag;

    typedef struct packed {
        t_phase              phase;
        logic                seen;
        logic                host;
        logic                path;
        logic [PORT_W-1:0]   port;
        logic                err;
    } t_state;

    typedef struct packed {
        t_tag                tag;
        logic [BYTE_W-1:0]   data;
        logic                done;
        logic                ok;
        logic [PORT_W-1:0]   port;
    } t_result;

endpackage

// ===== hdl/ufs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_core
// Combinational per-byte step: tags the byte and computes the next state.
// ----------------------------------------------------------------------------
module ufs_core (
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    input  logic [15:0]     i_start_port,
    input  ufs_pkg::t_state i_state,
    output ufs_pkg::t_state o_state,
    output ufs_pkg::t_result o_result
);
    import ufs_pkg::*;

    typedef struct packed {
        t_state             st;
        t_tag               tag;
        logic [BYTE_W-1:0]  data;
    } t_step;

    function automatic logic f_digit(input logic [BYTE_W-1:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic f_host_char(input logic [BYTE_W-1:0] b);
        return f_digit(b) || ((b >= CH_UP_A) && (b <= CH_UP_Z))
            || ((b >= CH_LO_A) && (b <= CH_LO_Z)) || (b == CH_DOT) || (b == CH_DASH);
    endfunction

    function automatic t_step f_select(input logic [BYTE_W-1:0] b, input t_state st);
        t_step r;
        r.st   = st;
        r.data = b;
        r.tag  = TAG_ERR;
        if (f_host_char(b)) begin
            if (st.host) begin
                r.st.err = 1'b1;
            end else begin
                r.st.host  = 1'b1;
                r.st.phase = PH_HOST;
                r.tag      = TAG_HOST;
            end
        end else if (b == CH_SLASH) begin
            if (st.path) begin
                r.st.err = 1'b1;
            end else begin
                r.st.path  = 1'b1;
                r.st.phase = PH_PATH;
                r.tag      = TAG_PATH;
            end
        end else if (b == CH_COLON) begin
            if (st.port != DEFAULT_PORT) begin
                r.st.err = 1'b1;
            end else begin
                r.st.port  = '0;
                r.st.phase = PH_PORT;
                r.tag      = TAG_DELIM;
            end
        end else if (b == CH_QUESTION) begin
            r.st.phase = PH_PARAM;
            r.tag      = TAG_DELIM;
        end else begin
            r.st.err = 1'b1;
        end
        return r;
    endfunction

    function automatic t_step f_step(input logic [BYTE_W-1:0] b, input t_state st_in,
                                     input logic [PORT_W-1:0] start_port);
        t_step              r;
        t_state             st;
        logic [PORT_W+3:0]  v;
        st = st_in;
        if ((st.phase == PH_SCHEME) && !st.seen && !st.err) begin
            st.port = start_port;
        end
        r.st   = st;
        r.data = b;
        r.tag  = TAG_ERR;
        v      = ({4'd0, st.port} << 3) + ({4'd0, st.port} << 1)
               + {{(PORT_W-BYTE_W+4){1'b0}}, (b - CH_ZERO)};
        if (!st.err) begin
            case (st.phase)
                PH_SCHEME: begin
                    if (b == CH_COLON) begin
                        if (!st.seen) begin
                            r.st.err = 1'b1;
                        end else begin
                            r.st.phase = PH_SLASH;
                            r.tag      = TAG_DELIM;
                        end
                    end else begin
                        r.st.seen = 1'b1;
                        if ((b > LOWER_BASE) && (b < ASCII_TOP)) begin
                            r.data = b - CASE_OFFSET;
                        end
                        r.tag = TAG_SCHEME;
                    end
                end
                PH_SLASH: begin
                    if (b == CH_SLASH) begin
                        r.tag = TAG_DELIM;
                    end else begin
                        r = f_select(b, st);
                    end
                end
                PH_HOST: begin
                    if (f_host_char(b)) begin
                        r.tag = TAG_HOST;
                    end else begin
                        r = f_select(b, st);
                    end
                end
                PH_PATH: begin
                    if (b == CH_QUESTION) begin
                        r = f_select(b, st);
                    end else begin
                        r.tag = TAG_PATH;
                    end
                end
                PH_PORT: begin
                    if (f_digit(b)) begin
                        r.st.port = (v > {4'd0, PORT_MAX}) ? PORT_MAX : v[PORT_W-1:0];
                        r.tag     = TAG_PORT;
                    end else begin
                        if (st.port == '0) begin
                            st.port = DEFAULT_PORT;
                        end
                        r = f_select(b, st);
                    end
                end
                PH_PARAM: begin
                    r.tag = TAG_PARAM;
                end
                default: begin
                    r = f_select(b, st);
                end
            endcase
        end
        return r;
    endfunction

    t_step step;

    always_comb begin
        step = f_step(i_byte, i_state, i_start_port);
    end

    // next state; the last byte restarts the URL
    always_comb begin
        o_state = step.st;
        if (i_last) begin
            o_state.phase = PH_SCHEME;
            o_state.seen  = 1'b0;
            o_state.host  = 1'b0;
            o_state.path  = 1'b0;
            o_state.port  = i_start_port;
            o_state.err   = 1'b0;
        end
    end

    always_comb begin
        o_result.tag  = step.tag;
        o_result.data = step.data;
        o_result.done = i_last;
        o_result.ok   = 1'b0;
        o_result.port = '0;
        if (i_last) begin
            o_result.ok = !step.st.err && (step.st.phase != PH_SCHEME);
            if ((step.st.phase == PH_PORT) && (step.st.port == '0)) begin
                o_result.port = DEFAULT_PORT;
            end else begin
                o_result.port = step.st.port;
            end
        end
    end

endmodule

// ===== hdl/url_field_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_field_splitter
// Streaming URL tagger: one byte in, one tagged byte out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: i_s_tdata carries one URL character, i_s_tlast marks the
//   final character of a URL. Master stream: one result per byte, with the
//   field tag in o_m_tuser, the done flag in o_m_tlast, and the character,
//   verdict and port in o_m_tdata (verdict and port are zero unless tlast).
//   Config channel: i_cfg_data sets the start port; always ready, write only
//   between URLs while no request is in flight.
//   Path: an accepted byte waits in the input register, and its result is
//   loaded into the result register once that register is empty or taken.
//   Throughput: one byte per cycle while the receiver takes each result; the
//   state update between the input and result registers is combinational.
//   Reset clears both stages and the parse state; the start port returns
//   to 80. When the receiver stalls, the result register holds, the input
//   register keeps one more byte, and i_s_tready then drops until the
//   result is taken.
// ----------------------------------------------------------------------------
module url_field_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] url_byte
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [ufs_pkg::ODATA_W-1:0] o_m_tdata, // [7:0] out_byte, [8] url_ok,
                                                   // [24:9] port_value
    output logic [2:0]  o_m_tuser,   // [2:0] field_tag
    output logic        o_m_tlast,   // done_res
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data   // start_port
);
    import ufs_pkg::*;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_in_last;
    logic               r_out_valid;
    t_result            r_out;
    t_state             r_state;
    logic [PORT_W-1:0]  r_start_port;

    t_state             n_state;
    t_result            n_out;
    logic               advance;

    ufs_core u_core (
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_start_port (r_start_port),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_start_port <= DEFAULT_PORT;
            r_state      <= '{phase: PH_SCHEME, seen: 1'b0, host: 1'b0, path: 1'b0,
                              port: DEFAULT_PORT, err: 1'b0};
        end else begin
            if (i_cfg_valid) begin
                r_start_port <= i_cfg_data;
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out.port, r_out.ok, r_out.data};
    assign o_m_tuser  = r_out.tag;
    assign o_m_tlast  = r_out.done;

endmodule
